/* rtl/clock_movement_pulse_driver_assert.svh */
// ----------------------------------------------------------------------------
// Clock movement pulse driver assertion macros
// Shared macros for the concurrent checks of the pulse driver.
// ----------------------------------------------------------------------------
`ifndef CLOCK_MOVEMENT_PULSE_DRIVER_ASSERT_SVH
`define CLOCK_MOVEMENT_PULSE_DRIVER_ASSERT_SVH

// A property that must hold at every clock edge outside of reset.
`define CMPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define CMPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/cmpd_pkg.sv */
// ----------------------------------------------------------------------------
// Clock movement pulse driver package
// Operation codes, register indexes, constants and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmpd_pkg;

  typedef enum logic [2:0] {
    OP_BASE_TICK      = 3'd0,
    OP_SECOND         = 3'd1,
    OP_MINUTE         = 3'd2,
    OP_FAST_FORWARD   = 3'd3,
    OP_SET_HANDS      = 3'd4,
    OP_ENABLE_MINUTES = 3'd5
  } op_t;

  localparam logic [1:0] CFG_PULSE_TICKS      = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS_TICKS = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE_TICKS   = 2'd2;

  localparam logic [7:0] PULSE_TICKS_RESET      = 8'd4;
  localparam logic [7:0] LONG_PRESS_TICKS_RESET = 8'd40;
  localparam logic [7:0] DEBOUNCE_TICKS_RESET   = 8'd2;

  localparam logic [9:0]  DIAL_LAST      = 10'd719;
  localparam logic [11:0] DIAL_MINUTES   = 12'd720;
  localparam logic [11:0] DIAL_TWICE     = 12'd1440;
  localparam logic [5:0]  SECOND_LAST    = 6'd59;
  localparam logic [5:0]  MINUTE_SECONDS = 6'd60;

  localparam logic [7:0] PAT_LONG   = 8'b0011_0011;
  localparam logic [7:0] PAT_SHORT  = 8'b0011_1111;
  localparam logic [7:0] PAT_SECOND = 8'b0000_0001;

  // Button state after the current word, plus LED pattern requests.
  typedef struct packed {
    logic short_press;
    logic long_press;
    logic idle;
    logic led_long;
    logic led_short;
  } button_status_t;

  typedef struct packed {
    logic       coil_positive;
    logic       coil_negative;
    logic       led_lit;
    logic       button_one_short;
    logic       button_one_long;
    logic       button_two_short;
    logic       button_two_long;
    logic [9:0] hand_minutes;
    logic       second_zero;
    logic       fast_forward_on;
    logic [9:0] steps_left;
  } result_t;

endpackage

/* rtl/cmpd_button.sv */
// ----------------------------------------------------------------------------
// Button debouncer
// Press counter and short/long flags for one button, advanced on base ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmpd_button (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     tick,
  input  logic                     down,
  input  logic [7:0]               long_press_ticks,
  input  logic [7:0]               debounce_ticks,
  output cmpd_pkg::button_status_t status
);
  import cmpd_pkg::*;

  logic [7:0] press_count;
  logic [7:0] press_count_next;
  logic       short_flag;
  logic       short_flag_next;
  logic       long_flag;
  logic       long_flag_next;
  logic [7:0] released_count;
  logic       led_long;
  logic       led_short;

  always_comb begin
    press_count_next = press_count;
    short_flag_next  = short_flag;
    long_flag_next   = long_flag;
    released_count   = long_flag ? 8'd0 : press_count;
    led_long         = 1'b0;
    led_short        = 1'b0;
    if (down) begin
      if (press_count != 8'hFF) begin
        press_count_next = press_count + 8'd1;
      end
      if (press_count > long_press_ticks) begin
        long_flag_next = 1'b1;
        led_long       = !long_flag;
      end
    end else begin
      long_flag_next = 1'b0;
      if (released_count > debounce_ticks) begin
        press_count_next = released_count - 8'd1;
        short_flag_next  = 1'b1;
      end else begin
        led_short        = (released_count != 8'd0);
        press_count_next = 8'd0;
        short_flag_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_count <= 8'd0;
      short_flag  <= 1'b0;
      long_flag   <= 1'b0;
    end else if (tick) begin
      press_count <= press_count_next;
      short_flag  <= short_flag_next;
      long_flag   <= long_flag_next;
    end
  end

  assign status.short_press = tick ? short_flag_next : short_flag;
  assign status.long_press  = tick ? long_flag_next : long_flag;
  assign status.idle        = (press_count == 8'd0);
  assign status.led_long    = tick && led_long;
  assign status.led_short   = tick && led_short;

endmodule

/* rtl/clock_movement_pulse_driver.sv */
// ----------------------------------------------------------------------------
// Clock movement pulse driver
// Single-coil stepper pulse generator with button debouncing and hand tracking.
// ----------------------------------------------------------------------------
// Every input word carries one event (base tick, second, minute trigger,
// fast-forward trigger, set hands, enable minutes) and yields exactly one
// result word that reports the coil drive, the LED bit shifted out, the four
// button flags, the hand position and the fast-forward status. The block
// takes one word per cycle while item_stall is low; all state updates for a
// word are made by combinational logic from the input ports straight into the
// registered result. Results go through a two-entry output buffer, so the
// input keeps flowing while one result waits to be taken; item_stall rises
// only when both entries are full. The three configuration registers are
// written through cfg_write, cfg_index and cfg_data; writes to an index past
// the last register are ignored.
`timescale 1ns / 1ps

module clock_movement_pulse_driver (
  input  logic       clk,
  input  logic       rst,
  // Configuration write port.
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Input words.
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [2:0] operation,
  input  logic       button_one_down,
  input  logic       button_two_down,
  input  logic [4:0] from_hour,
  input  logic [5:0] from_minute,
  input  logic [4:0] to_hour,
  input  logic [5:0] to_minute,
  // Result words.
  output logic       result_valid,
  input  logic       result_stall,
  output logic       coil_positive,
  output logic       coil_negative,
  output logic       led_lit,
  output logic       button_one_short,
  output logic       button_one_long,
  output logic       button_two_short,
  output logic       button_two_long,
  output logic [9:0] hand_minutes,
  output logic       second_zero,
  output logic       fast_forward_on,
  output logic [9:0] steps_left
);
  import cmpd_pkg::*;

  // Reduce an hour of 0..31 to 0..11.
  function automatic logic [3:0] hour_mod12(input logic [4:0] hour);
    logic [4:0] reduced;
    reduced = hour;
    if (hour >= 5'd24) begin
      reduced = hour - 5'd24;
    end else if (hour >= 5'd12) begin
      reduced = hour - 5'd12;
    end
    return reduced[3:0];
  endfunction

  // Minutes past twelve on the dial; at most 723 for out-of-range minutes.
  function automatic logic [9:0] dial_minutes(input logic [4:0] hour,
                                              input logic [5:0] minute);
    logic [9:0] hour_part;
    hour_part = 10'(hour_mod12(hour) * MINUTE_SECONDS);
    return hour_part + {4'd0, minute};
  endfunction

  // Configuration registers.
  logic [7:0] pulse_ticks;
  logic [7:0] long_press_ticks;
  logic [7:0] debounce_ticks;

  // Movement state.
  logic [7:0] pulse_count, pulse_count_next;
  logic       power_on, power_on_next;
  logic       polarity, polarity_next;
  logic       minute_enable, minute_enable_next;
  logic       fast_enable, fast_enable_next;
  logic [9:0] steps_remaining, steps_remaining_next;
  logic [9:0] hand_position, hand_position_next;
  logic [5:0] seconds_count, seconds_count_next;
  logic       second_zero_flag, second_zero_flag_next;
  logic [7:0] led_pattern, led_pattern_next;

  // Output buffer: head entry drives the ports, the spare catches overflow.
  result_t res, spare;
  logic    spare_valid;
  result_t result_next;

  logic           accept;
  logic           tick;
  logic           led_next;
  op_t            op;
  button_status_t button_one;
  button_status_t button_two;
  logic [7:0]     pulse_count_inc;
  logic [9:0]     steps_dec;
  logic [9:0]     hand_inc;
  logic [9:0]     from_total;
  logic [9:0]     to_total;
  logic [11:0]    distance_raw;
  logic [11:0]    distance_once;
  logic [11:0]    distance;

  assign item_stall = spare_valid;
  assign accept     = item_valid && !item_stall;
  assign op         = op_t'(operation);
  assign tick       = accept && (op == OP_BASE_TICK);

  cmpd_button u_button_one (
    .clk              (clk),
    .rst              (rst),
    .tick             (tick),
    .down             (button_one_down),
    .long_press_ticks (long_press_ticks),
    .debounce_ticks   (debounce_ticks),
    .status           (button_one)
  );

  cmpd_button u_button_two (
    .clk              (clk),
    .rst              (rst),
    .tick             (tick),
    .down             (button_two_down),
    .long_press_ticks (long_press_ticks),
    .debounce_ticks   (debounce_ticks),
    .status           (button_two)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks      <= PULSE_TICKS_RESET;
      long_press_ticks <= LONG_PRESS_TICKS_RESET;
      debounce_ticks   <= DEBOUNCE_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PULSE_TICKS:      pulse_ticks      <= cfg_data;
        CFG_LONG_PRESS_TICKS: long_press_ticks <= cfg_data;
        CFG_DEBOUNCE_TICKS:   debounce_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Forward distance from the shown time to the target time, in 0..719.
  // The raw sum lies in 717..2163, so two conditional subtractions suffice.
  assign from_total    = dial_minutes(from_hour, from_minute);
  assign to_total      = dial_minutes(to_hour, to_minute);
  assign distance_raw  = {2'd0, to_total} + DIAL_TWICE - {2'd0, from_total};
  assign distance_once = (distance_raw >= DIAL_TWICE) ? distance_raw - DIAL_TWICE
                                                      : distance_raw;
  assign distance      = (distance_once >= DIAL_MINUTES) ? distance_once - DIAL_MINUTES
                                                         : distance_once;

  assign hand_inc        = (hand_position == DIAL_LAST) ? 10'd0 : hand_position + 10'd1;
  assign pulse_count_inc = power_on ? pulse_count + 8'd1 : pulse_count;
  assign steps_dec       = (steps_remaining != 10'd0) ? steps_remaining - 10'd1
                                                      : steps_remaining;

  // Next state for the accepted word.
  always_comb begin
    pulse_count_next      = pulse_count;
    power_on_next         = power_on;
    polarity_next         = polarity;
    minute_enable_next    = minute_enable;
    fast_enable_next      = fast_enable;
    steps_remaining_next  = steps_remaining;
    hand_position_next    = hand_position;
    seconds_count_next    = seconds_count;
    second_zero_flag_next = second_zero_flag;
    led_pattern_next      = led_pattern;
    led_next              = 1'b0;
    unique case (op)
      OP_BASE_TICK: begin
        led_next         = led_pattern[0];
        led_pattern_next = {1'b0, led_pattern[7:1]};
        pulse_count_next = pulse_count_inc;
        // A pulse ends once its tick count passes the programmed width; the
        // polarity flips for the next step and fast-forward counts one down.
        if (pulse_count_inc > pulse_ticks) begin
          power_on_next    = 1'b0;
          pulse_count_next = 8'd0;
          polarity_next    = !polarity;
          if (fast_enable) begin
            steps_remaining_next = steps_dec;
            if (steps_dec == 10'd0) begin
              fast_enable_next   = 1'b0;
              minute_enable_next = 1'b1;
            end
          end
        end
        // Button one is handled before button two, so two wins a conflict.
        if (button_one.led_long) begin
          led_pattern_next = PAT_LONG;
        end
        if (button_one.led_short) begin
          led_pattern_next = PAT_SHORT;
        end
        if (button_two.led_long) begin
          led_pattern_next = PAT_LONG;
        end
        if (button_two.led_short) begin
          led_pattern_next = PAT_SHORT;
        end
      end
      OP_SECOND: begin
        if (button_one.idle && button_two.idle) begin
          led_pattern_next = PAT_SECOND;
        end
        seconds_count_next    = (seconds_count == SECOND_LAST) ? 6'd0
                                                               : seconds_count + 6'd1;
        second_zero_flag_next = (seconds_count == SECOND_LAST);
      end
      OP_MINUTE: begin
        if (minute_enable) begin
          power_on_next      = 1'b1;
          hand_position_next = hand_inc;
        end
      end
      OP_FAST_FORWARD: begin
        if (fast_enable) begin
          power_on_next      = 1'b1;
          hand_position_next = hand_inc;
        end
      end
      OP_SET_HANDS: begin
        steps_remaining_next = distance[9:0];
        if (distance != 12'd0) begin
          minute_enable_next = 1'b0;
          fast_enable_next   = 1'b1;
        end
      end
      OP_ENABLE_MINUTES: begin
        minute_enable_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    result_next.coil_positive    = power_on_next && polarity_next;
    result_next.coil_negative    = power_on_next && !polarity_next;
    result_next.led_lit          = led_next;
    result_next.button_one_short = button_one.short_press;
    result_next.button_one_long  = button_one.long_press;
    result_next.button_two_short = button_two.short_press;
    result_next.button_two_long  = button_two.long_press;
    result_next.hand_minutes     = hand_position_next;
    result_next.second_zero      = second_zero_flag_next;
    result_next.fast_forward_on  = fast_enable_next;
    result_next.steps_left       = steps_remaining_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count      <= 8'd0;
      power_on         <= 1'b0;
      polarity         <= 1'b0;
      minute_enable    <= 1'b0;
      fast_enable      <= 1'b0;
      steps_remaining  <= 10'd0;
      hand_position    <= 10'd0;
      seconds_count    <= 6'd0;
      second_zero_flag <= 1'b0;
      led_pattern      <= 8'd0;
    end else if (accept) begin
      pulse_count      <= pulse_count_next;
      power_on         <= power_on_next;
      polarity         <= polarity_next;
      minute_enable    <= minute_enable_next;
      fast_enable      <= fast_enable_next;
      steps_remaining  <= steps_remaining_next;
      hand_position    <= hand_position_next;
      seconds_count    <= seconds_count_next;
      second_zero_flag <= second_zero_flag_next;
      led_pattern      <= led_pattern_next;
    end
  end

  // Output buffer control. The spare entry fills only when the head is held,
  // and while it is full no new word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      spare_valid  <= 1'b0;
    end else if (result_valid && !result_stall) begin
      if (spare_valid) begin
        spare_valid <= 1'b0;
      end else begin
        result_valid <= accept;
      end
    end else if (accept) begin
      if (result_valid) begin
        spare_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && !result_stall) begin
      res <= spare_valid ? spare : result_next;
    end else if (accept) begin
      if (result_valid) begin
        spare <= result_next;
      end else begin
        res <= result_next;
      end
    end
  end

  assign coil_positive    = res.coil_positive;
  assign coil_negative    = res.coil_negative;
  assign led_lit          = res.led_lit;
  assign button_one_short = res.button_one_short;
  assign button_one_long  = res.button_one_long;
  assign button_two_short = res.button_two_short;
  assign button_two_long  = res.button_two_long;
  assign hand_minutes     = res.hand_minutes;
  assign second_zero      = res.second_zero;
  assign fast_forward_on  = res.fast_forward_on;
  assign steps_left       = res.steps_left;

endmodule

/* rtl/cmpd_checker.sv */
// ----------------------------------------------------------------------------
// Clock movement pulse driver checker
// Port-level checks on the result channel of the pulse driver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "clock_movement_pulse_driver_assert.svh"

module cmpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic       coil_positive,
  input logic       coil_negative,
  input logic [9:0] hand_minutes,
  input logic [9:0] steps_left
);

  `CMPD_ASSERT(coil_exclusive, clk, rst, !(result_valid && coil_positive && coil_negative), "coil driven with both polarities")
  `CMPD_ASSERT(hand_in_dial, clk, rst, !(result_valid && (hand_minutes > 10'd719)), "hand position outside the dial")
  `CMPD_ASSERT(steps_in_dial, clk, rst, !(result_valid && (steps_left > 10'd719)), "fast-forward steps outside the dial")
  `CMPD_ASSERT_NEXT(result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(hand_minutes) && $stable(steps_left), "stalled result word changed")

endmodule

bind clock_movement_pulse_driver cmpd_checker u_cmpd_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .coil_positive (coil_positive),
  .coil_negative (coil_negative),
  .hand_minutes  (hand_minutes),
  .steps_left    (steps_left)
);
